// ===== design/asb_pkg.sv =====
package asb_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_BLEND = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  // Work classified by the front end for the back end
  typedef enum logic [1:0] {
    OP_BLEND = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SKIP  = 2'd3
  } cmd_op_e;

  // Back-end sequencer states
  typedef enum logic {
    BS_IDLE = 1'b0,
    BS_EXEC = 1'b1
  } back_state_e;

  localparam int unsigned ChanMax = 255;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [3:0]  texel_col;
    logic [3:0]  texel_row;
    logic [7:0]  texel_red;
    logic [7:0]  texel_green;
    logic [7:0]  texel_blue;
    logic [7:0]  tint_red;
    logic [7:0]  tint_green;
    logic [7:0]  tint_blue;
  } in_beat_t;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        in_bounds;
  } out_beat_t;

  // Classified command: operation and the tinted texel products
  typedef struct packed {
    cmd_op_e     op;
    logic [15:0] prod_red;
    logic [15:0] prod_green;
    logic [15:0] prod_blue;
  } cmd_t;

  // Saturating add of old + prod / 255; prod never exceeds 255 * 255
  function automatic logic [7:0] blend_chan(input logic [7:0] old_c, input logic [15:0] prod);
    logic [16:0] corr;
    logic [7:0]  quot;
    logic [8:0]  sum;
    corr = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    quot = corr[15:8];
    sum  = 9'(old_c) + 9'(quot);
    blend_chan = (sum > 9'(ChanMax)) ? 8'(ChanMax) : sum[7:0];
  endfunction

endpackage

// ===== design/additive_sprite_blender.sv =====
// Additive sprite blender over a row-major frame store of 24-bit RGB pixels.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one request per
// beat: blend a tinted texel onto a pixel, read a pixel, or clear a pixel.
// Output channel (out_valid_o / out_ready_i / out_data_o) returns one beat per
// request: the resulting or read pixel and an in-bounds flag; out-of-screen,
// out-of-sprite and unknown requests return zero with in_bounds low.
// The front end classifies a request and computes its address and tint
// products in the accept cycle, then parks it in a two-entry queue.
// The back end pops one command, reads the frame store (one registered read
// port), then blends, writes back and loads the output register.
// The back end pops a new command only after the previous one has fired, so
// it works on one command at a time while the queue keeps accepting requests.
// Reset clears the queue, the sequencer and the output valid; the frame store
// is not cleared, so each pixel must be cleared or written before it is read.
// When the receiver stalls, the result holds in the output register, one more
// request waits in the back end and two in the queue before in_ready_o drops.
module additive_sprite_blender #(
  parameter int unsigned SCREEN_COLS = 800,
  parameter int unsigned SCREEN_ROWS = 600,
  parameter int unsigned SPRITE_SIZE = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  asb_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output asb_pkg::out_beat_t out_data_o
);
  import asb_pkg::*;

  localparam int unsigned AddrW  = $clog2(SCREEN_COLS * SCREEN_ROWS);
  localparam int unsigned QWidth = $bits(cmd_t) + AddrW;

  cmd_t              front_cmd;
  logic [AddrW-1:0]  front_addr;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [QWidth-1:0] q_head;
  logic              push;
  cmd_t              head_cmd;
  logic [AddrW-1:0]  head_addr;

  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;

  asb_front #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .SPRITE_SIZE (SPRITE_SIZE),
    .AddrW       (AddrW)
  ) u_front (
    .in_data_i (in_data_i),
    .cmd_o     (front_cmd),
    .addr_o    (front_addr)
  );

  asb_queue #(
    .Width (QWidth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({front_cmd, front_addr}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  assign head_cmd  = q_head[QWidth-1:AddrW];
  assign head_addr = q_head[AddrW-1:0];

  asb_back #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .AddrW       (AddrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_cmd_i  (head_cmd),
    .head_addr_i (head_addr),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/asb_front.sv =====
module asb_front #(
  parameter int unsigned SCREEN_COLS = 800,
  parameter int unsigned SCREEN_ROWS = 600,
  parameter int unsigned SPRITE_SIZE = 16,
  parameter int unsigned AddrW       = $clog2(SCREEN_COLS * SCREEN_ROWS)
) (
  input  asb_pkg::in_beat_t  in_data_i,
  output asb_pkg::cmd_t      cmd_o,
  output logic [AddrW-1:0]   addr_o
);
  import asb_pkg::*;

  localparam int unsigned ColW = $clog2(SCREEN_COLS);
  localparam int unsigned RowW = $clog2(SCREEN_ROWS);

  logic [15:0] tgt_x;
  logic [15:0] tgt_y;
  logic        is_blend;
  logic        in_sprite;
  logic        in_screen;
  logic [AddrW-1:0] lin_addr;

  // Form the target pixel, wrapping at 16 bits for blends
  assign is_blend  = (in_data_i.req_type == REQ_BLEND);
  assign tgt_x     = is_blend ? in_data_i.origin_x + 16'(in_data_i.texel_col)
                              : in_data_i.origin_x;
  assign tgt_y     = is_blend ? in_data_i.origin_y + 16'(in_data_i.texel_row)
                              : in_data_i.origin_y;
  assign in_sprite = (32'(in_data_i.texel_col) < SPRITE_SIZE) &&
                     (32'(in_data_i.texel_row) < SPRITE_SIZE);
  assign in_screen = (32'(tgt_x) < SCREEN_COLS) && (32'(tgt_y) < SCREEN_ROWS);

  // Row-major linear address
  assign lin_addr = AddrW'(tgt_y[RowW-1:0]) * AddrW'(SCREEN_COLS) + AddrW'(tgt_x[ColW-1:0]);

  // Classify the request
  always_comb begin
    cmd_o.prod_red   = 16'(in_data_i.texel_red)   * 16'(in_data_i.tint_red);
    cmd_o.prod_green = 16'(in_data_i.texel_green) * 16'(in_data_i.tint_green);
    cmd_o.prod_blue  = 16'(in_data_i.texel_blue)  * 16'(in_data_i.tint_blue);
    cmd_o.op         = OP_SKIP;
    case (in_data_i.req_type)
      REQ_BLEND: begin
        if (in_sprite && in_screen) cmd_o.op = OP_BLEND;
      end
      REQ_READ: begin
        if (in_screen) cmd_o.op = OP_READ;
      end
      REQ_CLEAR: begin
        if (in_screen) cmd_o.op = OP_CLEAR;
      end
      default: cmd_o.op = OP_SKIP;
    endcase
    addr_o = (cmd_o.op == OP_SKIP) ? '0 : lin_addr;
  end

endmodule

// ===== design/asb_queue.sv =====
module asb_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] head_o,
  output logic             empty_o
);
  import asb_pkg::*;

  logic [Width-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold the queued beats
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

endmodule

// ===== design/asb_back.sv =====
module asb_back #(
  parameter int unsigned SCREEN_COLS = 800,
  parameter int unsigned SCREEN_ROWS = 600,
  parameter int unsigned AddrW       = $clog2(SCREEN_COLS * SCREEN_ROWS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  asb_pkg::cmd_t      head_cmd_i,
  input  logic [AddrW-1:0]   head_addr_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output asb_pkg::out_beat_t out_data_o
);
  import asb_pkg::*;

  localparam int unsigned Depth = SCREEN_COLS * SCREEN_ROWS;

  logic [23:0]      mem [Depth];
  logic [23:0]      rdata_q;
  back_state_e      state_q, state_d;
  cmd_t             cmd_q;
  logic [AddrW-1:0] addr_q;
  logic             fire;
  logic             wr_en;
  logic [23:0]      wr_data;
  logic [23:0]      blended;
  out_beat_t        result;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_data_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE: begin
        if (!empty_i) state_d = BS_EXEC;
      end
      BS_EXEC: begin
        if (!out_valid_q || out_ready_i) state_d = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop_o = 1'b0;
    fire  = 1'b0;
    case (state_q)
      BS_IDLE: pop_o = !empty_i;
      BS_EXEC: fire  = !out_valid_q || out_ready_i;
      default: begin
        pop_o = 1'b0;
        fire  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BS_IDLE;
    else         state_q <= state_d;
  end

  // Latch the popped command
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q  <= head_cmd_i;
      addr_q <= head_addr_i;
    end
  end

  // Read the old pixel
  always_ff @(posedge clk_i) begin
    if (pop_o) rdata_q <= mem[head_addr_i];
  end

  // Blend each channel
  assign blended = {blend_chan(rdata_q[23:16], cmd_q.prod_red),
                    blend_chan(rdata_q[15:8],  cmd_q.prod_green),
                    blend_chan(rdata_q[7:0],   cmd_q.prod_blue)};

  // Select result and write-back
  always_comb begin
    result.pixel_rgb = '0;
    result.in_bounds = 1'b1;
    wr_en            = 1'b0;
    wr_data          = '0;
    case (cmd_q.op)
      OP_BLEND: begin
        result.pixel_rgb = blended;
        wr_en            = fire;
        wr_data          = blended;
      end
      OP_READ:  result.pixel_rgb = rdata_q;
      OP_CLEAR: wr_en = fire;
      default:  result.in_bounds = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[addr_q] <= wr_data;
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire)             out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_data_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_pop_enters_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == BS_EXEC) else $error("pop did not start execution");
  a_write_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == BS_EXEC) && (cmd_q.op == OP_BLEND || cmd_q.op == OP_CLEAR))
    else $error("store written outside blend or clear");
  a_fire_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q) else $error("result not presented");

endmodule

// ===== test/additive_sprite_blender_tb.sv =====
`timescale 1ns / 100ps

module additive_sprite_blender_tb;
  import asb_pkg::*;

  localparam int unsigned ScreenCols = 800;
  localparam int unsigned ScreenRows = 600;
  localparam int unsigned SpriteSize = 16;
  localparam int unsigned InBits     = $bits(in_beat_t);
  localparam int unsigned RandomReqs = 800;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned MaxReports = 10;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_data_o;

  // Shadow frame store: an entry exists only once the pixel has been written
  logic [23:0] shadow_pixels [int unsigned];
  int unsigned written_idx[$];
  int unsigned last_target;
  out_beat_t   pending_pixels[$];

  bit          gaps_off    = 1'b0;
  int unsigned fail_cnt    = 0;
  int unsigned result_cnt  = 0;
  int unsigned blend_cnt   = 0;
  int unsigned read_cnt    = 0;
  int unsigned clear_cnt   = 0;
  int unsigned dropped_cnt = 0;
  int unsigned cycle_cnt   = 0;

  additive_sprite_blender #(
    .SCREEN_COLS(ScreenCols),
    .SCREEN_ROWS(ScreenRows),
    .SPRITE_SIZE(SpriteSize)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_cnt,
               pending_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One channel of an additive blend, clamped at full scale
  function automatic logic [7:0] add_tinted(input logic [7:0] old_c, input logic [7:0] texel,
                                            input logic [7:0] tint);
    int unsigned sum;
    sum = int'(old_c) + (int'(texel) * int'(tint)) / ChanMax;
    return (sum > ChanMax) ? 8'(ChanMax) : sum[7:0];
  endfunction

  // Update the shadow store for one request and return the pixel it yields
  function automatic out_beat_t apply_request(input in_beat_t b);
    out_beat_t   res;
    logic [15:0] tx;
    logic [15:0] ty;
    int unsigned idx;
    logic [23:0] old_px;
    res = '0;
    case (b.req_type)
      REQ_BLEND: begin
        tx = b.origin_x + 16'(b.texel_col);
        ty = b.origin_y + 16'(b.texel_row);
        if (b.texel_col < SpriteSize && b.texel_row < SpriteSize &&
            tx < ScreenCols && ty < ScreenRows) begin
          idx = int'(ty) * ScreenCols + int'(tx);
          old_px = shadow_pixels.exists(idx) ? shadow_pixels[idx] : 24'd0;
          res.pixel_rgb = {add_tinted(old_px[23:16], b.texel_red, b.tint_red),
                           add_tinted(old_px[15:8], b.texel_green, b.tint_green),
                           add_tinted(old_px[7:0], b.texel_blue, b.tint_blue)};
          res.in_bounds = 1'b1;
          shadow_pixels[idx] = res.pixel_rgb;
          blend_cnt++;
        end else begin
          dropped_cnt++;
        end
      end
      REQ_READ, REQ_CLEAR: begin
        if (b.origin_x < ScreenCols && b.origin_y < ScreenRows) begin
          idx = int'(b.origin_y) * ScreenCols + int'(b.origin_x);
          res.in_bounds = 1'b1;
          if (b.req_type == REQ_READ) begin
            res.pixel_rgb = shadow_pixels[idx];
            read_cnt++;
          end else begin
            if (!shadow_pixels.exists(idx)) written_idx.push_back(idx);
            shadow_pixels[idx] = 24'd0;
            clear_cnt++;
          end
        end else begin
          dropped_cnt++;
        end
      end
      default: dropped_cnt++;
    endcase
    return res;
  endfunction

  // Build a request from explicit fields
  function automatic in_beat_t make_req(input req_type_e kind, input logic [15:0] x,
                                        input logic [15:0] y, input logic [3:0] tc,
                                        input logic [3:0] tr, input logic [23:0] texel,
                                        input logic [23:0] tint);
    in_beat_t b;
    b.req_type    = kind;
    b.origin_x    = x;
    b.origin_y    = y;
    b.texel_col   = tc;
    b.texel_row   = tr;
    b.texel_red   = texel[23:16];
    b.texel_green = texel[15:8];
    b.texel_blue  = texel[7:0];
    b.tint_red    = tint[23:16];
    b.tint_green  = tint[15:8];
    b.tint_blue   = tint[7:0];
    return b;
  endfunction

  // Point a request at a stored pixel; a blend backs the origin off by the texel offset
  function automatic void aim_at(inout in_beat_t b, input req_type_e kind,
                                 input int unsigned idx);
    int unsigned tx;
    int unsigned ty;
    tx = idx % ScreenCols;
    ty = idx / ScreenCols;
    b.req_type = kind;
    if (kind == REQ_BLEND) begin
      b.origin_x = 16'(tx - b.texel_col);
      b.origin_y = 16'(ty - b.texel_row);
    end else begin
      b.origin_x = 16'(tx);
      b.origin_y = 16'(ty);
    end
    last_target = idx;
  endfunction

  // Hold one beat on the input until it is taken, then log its expected pixel
  task automatic send_request(input in_beat_t b);
    int unsigned gap;
    gap = gaps_off ? 0 : $urandom_range(3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pixels.push_back(apply_request(b));
  endtask

  // Compare one output beat against the oldest expectation
  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    result_cnt++;
    if (pending_pixels.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= MaxReports)
        $display("ERROR: unexpected result pixel_rgb=%06h in_bounds=%0b",
                 got.pixel_rgb, got.in_bounds);
    end else begin
      want = pending_pixels.pop_front();
      if (got.pixel_rgb !== want.pixel_rgb || got.in_bounds !== want.in_bounds) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports)
          $display("ERROR: result %0d pixel_rgb exp %06h got %06h, in_bounds exp %0b got %0b",
                   result_cnt, want.pixel_rgb, got.pixel_rgb, want.in_bounds, got.in_bounds);
      end
    end
  endtask

  // Receive results with random stalls
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = gaps_off ? 0 : $urandom_range(3);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_data_o);
    end
  end

  // Corners, clipping, wrap of the origin, saturation and the unknown request
  task automatic test_directed_edges();
    send_request(make_req(REQ_CLEAR, 16'd0, 16'd0, 4'd0, 4'd0, 24'h0, 24'h0));
    send_request(make_req(REQ_CLEAR, 16'd799, 16'd0, 4'd15, 4'd15, 24'hffffff, 24'hffffff));
    send_request(make_req(REQ_CLEAR, 16'd0, 16'd599, 4'd0, 4'd0, 24'h0, 24'h0));
    send_request(make_req(REQ_CLEAR, 16'd799, 16'd599, 4'd0, 4'd0, 24'h0, 24'h0));
    send_request(make_req(REQ_CLEAR, 16'd800, 16'd0, 4'd0, 4'd0, 24'h0, 24'h0));
    send_request(make_req(REQ_CLEAR, 16'd0, 16'd600, 4'd0, 4'd0, 24'h0, 24'h0));
    send_request(make_req(REQ_READ, 16'd799, 16'd599, 4'd15, 4'd15, 24'hffffff, 24'hffffff));
    // origin wraps around to the top-left pixel
    send_request(make_req(REQ_BLEND, 16'hffff, 16'hffff, 4'd1, 4'd1, 24'hffffff, 24'hffffff));
    send_request(make_req(REQ_BLEND, 16'hffff, 16'hffff, 4'd1, 4'd1, 24'hffffff, 24'hffffff));
    send_request(make_req(REQ_READ, 16'd0, 16'd0, 4'd0, 4'd0, 24'h0, 24'h0));
    send_request(make_req(REQ_BLEND, 16'd784, 16'd584, 4'd15, 4'd15, 24'h000000, 24'hffffff));
    send_request(make_req(REQ_BLEND, 16'd799, 16'd599, 4'd0, 4'd0, 24'hffffff, 24'h010101));
    send_request(make_req(REQ_BLEND, 16'd799, 16'd599, 4'd0, 4'd0, 24'h8001fe, 24'hff01fe));
    // targets just off the right and bottom edges
    send_request(make_req(REQ_BLEND, 16'd799, 16'd599, 4'd1, 4'd0, 24'hffffff, 24'hffffff));
    send_request(make_req(REQ_BLEND, 16'd799, 16'd599, 4'd0, 4'd1, 24'hffffff, 24'hffffff));
    send_request(make_req(REQ_BLEND, 16'hffff, 16'd0, 4'd0, 4'd0, 24'hffffff, 24'hffffff));
    send_request(make_req(REQ_READ, 16'hffff, 16'hffff, 4'd0, 4'd0, 24'h0, 24'h0));
    send_request(make_req(REQ_NONE, 16'd0, 16'd0, 4'd15, 4'd15, 24'hffffff, 24'hffffff));
    send_request(make_req(REQ_CLEAR, 16'd0, 16'd0, 4'd0, 4'd0, 24'h0, 24'h0));
    send_request(make_req(REQ_READ, 16'd0, 16'd0, 4'd0, 4'd0, 24'h0, 24'h0));
    send_request(make_req(REQ_READ, 16'd799, 16'd0, 4'd9, 4'd6, 24'h5a5a5a, 24'ha5a5a5));
  endtask

  // Pick an on-screen pixel, often near a corner
  task automatic pick_pixel(output logic [15:0] x, output logic [15:0] y);
    if ($urandom_range(1)) begin
      x = $urandom_range(1) ? 16'($urandom_range(7)) : 16'(ScreenCols - 8 + $urandom_range(7));
      y = $urandom_range(1) ? 16'($urandom_range(7)) : 16'(ScreenRows - 8 + $urandom_range(7));
    end else begin
      x = 16'($urandom_range(ScreenCols - 1));
      y = 16'($urandom_range(ScreenRows - 1));
    end
  endtask

  // Draw a request: mostly traffic on stored pixels, some noise
  task automatic random_request(output in_beat_t b);
    int unsigned sel;
    int unsigned idx;
    logic [15:0] tx;
    logic [15:0] ty;
    b = in_beat_t'(InBits'({$urandom(), $urandom(), $urandom()}));
    sel = $urandom_range(99);
    if (sel < 15 || written_idx.size() == 0) begin
      b.req_type = REQ_CLEAR;
      pick_pixel(b.origin_x, b.origin_y);
    end else if (sel < 75) begin
      idx = ($urandom_range(4) == 0) ? last_target
                                     : written_idx[$urandom_range(written_idx.size() - 1)];
      aim_at(b, (sel < 55) ? REQ_BLEND : REQ_READ, idx);
    end else if (sel < 85) begin
      b.req_type = REQ_BLEND;
    end else if (sel < 94) begin
      b.req_type = $urandom_range(1) ? REQ_READ : REQ_CLEAR;
    end else begin
      b.req_type = REQ_NONE;
    end
    // drop any noise that would touch a never-written pixel
    tx = b.origin_x;
    ty = b.origin_y;
    if (b.req_type == REQ_BLEND) begin
      tx = b.origin_x + 16'(b.texel_col);
      ty = b.origin_y + 16'(b.texel_row);
    end
    if ((b.req_type == REQ_BLEND || b.req_type == REQ_READ) &&
        tx < ScreenCols && ty < ScreenRows &&
        !shadow_pixels.exists(int'(ty) * ScreenCols + int'(tx)))
      b.req_type = REQ_NONE;
  endtask

  // Back-to-back hits on a few pixels with no idle cycles on either side
  task automatic test_same_pixel_bursts();
    in_beat_t    b;
    int unsigned idx;
    gaps_off = 1'b1;
    repeat (6) begin
      idx = written_idx[$urandom_range(written_idx.size() - 1)];
      repeat (8) begin
        b = in_beat_t'(InBits'({$urandom(), $urandom(), $urandom()}));
        aim_at(b, ($urandom_range(3) == 0) ? REQ_READ : REQ_BLEND, idx);
        send_request(b);
      end
    end
    gaps_off = 1'b0;
  endtask

  // Random traffic with stretches of full rate
  task automatic test_random_traffic();
    in_beat_t b;
    for (int unsigned n = 0; n < RandomReqs; n++) begin
      if (n % 100 == 0) gaps_off = ($urandom_range(3) == 0);
      random_request(b);
      send_request(b);
    end
    gaps_off = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_edges();
    test_same_pixel_bursts();
    test_random_traffic();
    // drain the pipeline
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_pixels.size() != 0) fail_cnt++;
    $display("Checked %0d results: %0d blends, %0d reads, %0d clears in bounds",
             result_cnt, blend_cnt, read_cnt, clear_cnt);
    $display("%0d requests clipped or unknown, %0d pixels touched, %0d mismatches",
             dropped_cnt, written_idx.size(), fail_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
